FILE: rtl/assert_macros.svh
// Assertion macros shared by the deque RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DQ_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define DQ_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("expected next-cycle condition missing");
`else
`define DQ_ASSERT_ALWAYS(lbl, expr)
`define DQ_ASSERT_NEVER(lbl, expr)
`define DQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/dq_pkg.sv
// Shared constants, codes and the cell control struct of the deque.
// Depends on nothing; used by dq_cell and double_ended_queue_top.
`default_nettype none
package dq_pkg;
	localparam int DATA_W    = 32;
	localparam int MAX_DEPTH = 64;
	localparam int CNT_W     = 7;
	localparam int GRP_SIZE  = 8;

	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_SHOW       = 3'd4;

	localparam logic [2:0] STAT_SHOWN   = 3'd0;
	localparam logic [2:0] STAT_EMPTY   = 3'd1;
	localparam logic [2:0] STAT_PUSHED  = 3'd2;
	localparam logic [2:0] STAT_POPPED  = 3'd3;
	localparam logic [2:0] STAT_DROPPED = 3'd4;

	typedef logic [2:0] cell_op_t;
	localparam cell_op_t CELL_HOLD       = 3'd0;
	localparam cell_op_t CELL_PUSH_FRONT = 3'd1;
	localparam cell_op_t CELL_PUSH_BACK  = 3'd2;
	localparam cell_op_t CELL_POP_FRONT  = 3'd3;
	localparam cell_op_t CELL_ROTATE     = 3'd4;

	typedef struct packed {
		cell_op_t             op;
		logic [CNT_W-1:0]     count;
		logic [DATA_W-1:0]    value;
	} dq_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/dq_cell.sv
// One storage cell of the deque chain: holds one element, shifts to either neighbor.
// Depends on dq_pkg for the control struct and the cell operation codes.
`default_nettype none
module dq_cell (
	input  wire                          clk,
	input  wire dq_pkg::dq_ctl_t         ctl,
	input  wire [dq_pkg::CNT_W-1:0]      idx,
	input  wire [dq_pkg::DATA_W-1:0]     left_data,
	input  wire [dq_pkg::DATA_W-1:0]     right_data,
	output logic [dq_pkg::DATA_W-1:0]    data,
	output logic [dq_pkg::DATA_W-1:0]    tap
);
	logic [dq_pkg::DATA_W-1:0] data_q;
	logic                      is_tail;
	logic                      is_free;

	assign is_tail = (ctl.count != '0) && (idx == ctl.count - 1'b1);
	assign is_free = (idx == ctl.count);

	always_ff @(posedge clk) begin
		case (ctl.op)
			dq_pkg::CELL_PUSH_FRONT: data_q <= left_data;
			dq_pkg::CELL_PUSH_BACK: begin
				if (is_free) begin
					data_q <= ctl.value;
				end
			end
			dq_pkg::CELL_POP_FRONT: data_q <= right_data;
			// The tail cell takes the old front element so the ring closes.
			dq_pkg::CELL_ROTATE: data_q <= is_tail ? ctl.value : right_data;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign tap  = is_tail ? data_q : '0;
endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_top.sv
// Top level of the bounded deque: cell chain, back-read OR tree, request sequencer.
// Depends on dq_pkg, dq_cell and assert_macros.svh.
//
// Usage: requests arrive on the in channel (in_valid/in_ready, req_type, push_value);
// results leave on the out channel (out_valid/out_ready, status, out_value, last).
// Elements sit in a chain of DEPTH cells, front in cell 0. Push front and pop
// front shift the whole chain by one cell; push back writes the cell at the count.
// Push, pop front and every empty or full answer appear in the cycle after the beat
// is accepted. Pop back goes through the pop-back state while the tail is gathered
// by a registered OR tree of the cell taps. Show rotates the chain one cell per beat
// for count beats, one beat per cycle while the receiver is ready, so the contents
// end unchanged. A new request is taken when the sequencer is idle and the output
// register is empty or being drained in the same cycle, so push and pop front run
// back to back while the receiver drains; pop back waits in that state. Request
// codes five to seven are taken and answered with nothing. Reset empties the queue
// and the output register; cell contents are not cleared. When the receiver stalls,
// the output register holds its beat and the sequencer waits, also during a show.
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue_top #(
	parameter int DEPTH = dq_pkg::MAX_DEPTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [2:0]                         req_type,
	input  wire signed [dq_pkg::DATA_W-1:0]   push_value,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [2:0]                        status,
	output logic signed [dq_pkg::DATA_W-1:0]  out_value,
	output logic                              last
);
	localparam int NGRP = (DEPTH + dq_pkg::GRP_SIZE - 1) / dq_pkg::GRP_SIZE;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POPB = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]                  state_q, state_d;
	logic [dq_pkg::CNT_W-1:0]    count_q, count_d;
	logic [dq_pkg::CNT_W-1:0]    rem_q, rem_d;
	logic                        out_valid_q;
	logic [2:0]                  status_q;
	logic [dq_pkg::DATA_W-1:0]   out_value_q;
	logic                        last_q;

	logic                        in_fire, out_free, full, empty;
	logic                        load_out;
	logic [2:0]                  res_status;
	logic [dq_pkg::DATA_W-1:0]   res_value;
	logic                        res_last;
	dq_pkg::dq_ctl_t             ctl;

	logic [dq_pkg::DATA_W-1:0]   cell_data  [DEPTH];
	logic [dq_pkg::DATA_W-1:0]   cell_tap   [DEPTH];
	logic [dq_pkg::DATA_W-1:0]   left_d     [DEPTH];
	logic [dq_pkg::DATA_W-1:0]   right_d    [DEPTH];
	logic [dq_pkg::DATA_W-1:0]   grp_or     [NGRP];
	logic [dq_pkg::DATA_W-1:0]   grp_s1     [NGRP];
	logic [dq_pkg::DATA_W-1:0]   back_value;

	assign full     = (count_q == dq_pkg::CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;

	// Cell chain.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_d[i] = ctl.value;
		end else begin : g_mid_l
			assign left_d[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d[i] = cell_data[i];
		end else begin : g_mid_r
			assign right_d[i] = cell_data[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (dq_pkg::CNT_W'(i)),
			.left_data  (left_d[i]),
			.right_data (right_d[i]),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	// Only the tail cell drives a nonzero tap, so OR-ing the taps selects it.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < dq_pkg::GRP_SIZE; k++) begin
				if (g * dq_pkg::GRP_SIZE + k < DEPTH) begin
					grp_or[g] = grp_or[g] | cell_tap[g * dq_pkg::GRP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_s1[g] <= grp_or[g];
		end
	end

	always_comb begin
		back_value = '0;
		for (int g = 0; g < NGRP; g++) begin
			back_value = back_value | grp_s1[g];
		end
	end

	// Request sequencer.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		load_out   = 1'b0;
		res_status = dq_pkg::STAT_SHOWN;
		res_value  = '0;
		res_last   = 1'b1;
		ctl.op     = dq_pkg::CELL_HOLD;
		ctl.count  = count_q;
		ctl.value  = (state_q == ST_SHOW) ? cell_data[0] : push_value;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (req_type) inside
						dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
							load_out = 1'b1;
							if (full) begin
								res_status = dq_pkg::STAT_DROPPED;
							end else begin
								res_status = dq_pkg::STAT_PUSHED;
								count_d    = count_q + 1'b1;
								ctl.op     = (req_type == dq_pkg::REQ_PUSH_BACK) ?
									dq_pkg::CELL_PUSH_BACK : dq_pkg::CELL_PUSH_FRONT;
							end
						end
						dq_pkg::REQ_POP_FRONT: begin
							load_out = 1'b1;
							if (empty) begin
								res_status = dq_pkg::STAT_EMPTY;
							end else begin
								res_status = dq_pkg::STAT_POPPED;
								res_value  = cell_data[0];
								count_d    = count_q - 1'b1;
								ctl.op     = dq_pkg::CELL_POP_FRONT;
							end
						end
						dq_pkg::REQ_POP_BACK: begin
							if (empty) begin
								load_out   = 1'b1;
								res_status = dq_pkg::STAT_EMPTY;
							end else begin
								state_d = ST_POPB;
							end
						end
						dq_pkg::REQ_SHOW: begin
							if (empty) begin
								load_out   = 1'b1;
								res_status = dq_pkg::STAT_EMPTY;
							end else begin
								state_d = ST_SHOW;
								rem_d   = count_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_POPB: begin
				load_out   = 1'b1;
				res_status = dq_pkg::STAT_POPPED;
				res_value  = back_value;
				count_d    = count_q - 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SHOW: begin
				if (out_free) begin
					load_out   = 1'b1;
					res_status = dq_pkg::STAT_SHOWN;
					res_value  = cell_data[0];
					res_last   = (rem_q == dq_pkg::CNT_W'(1));
					rem_d      = rem_q - 1'b1;
					ctl.op     = dq_pkg::CELL_ROTATE;
					if (rem_q == dq_pkg::CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= res_status;
			out_value_q <= res_value;
			last_q      <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	`DQ_ASSERT_ALWAYS(a_count_bound, count_q <= dq_pkg::CNT_W'(DEPTH))
	`DQ_ASSERT_NEVER(a_show_rem, (state_q == ST_SHOW) && (rem_q == '0 || rem_q > count_q))
	`DQ_ASSERT_NEVER(a_popb_slot_free, (state_q == ST_POPB) && out_valid_q)
	`DQ_ASSERT_NEXT(a_push_grows,
		in_fire && !full && (req_type == dq_pkg::REQ_PUSH_BACK ||
		req_type == dq_pkg::REQ_PUSH_FRONT), count_q == $past(count_q) + 1'b1)
endmodule
`default_nettype wire
